@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the core top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, checked outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/core/lcv_pkg.sv @@
package lcv_pkg;

    localparam int KEY_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CAP_RST = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic cmp;
        logic upd;
        logic hit;
        logic put;
    } t_cell_ctl;

endpackage

@@ rtl/core/lcv_cell.sv @@
module lcv_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lcv_pkg::t_cell_ctl                   i_ctl,
    input  logic [CW-1:0]                        i_count,
    input  logic signed [lcv_pkg::KEY_W-1:0]     i_req_key,
    input  logic signed [lcv_pkg::KEY_W-1:0]     i_prev_key,
    input  logic signed [lcv_pkg::KEY_W-1:0]     i_prev_value,
    input  logic                                 i_above,
    input  logic signed [lcv_pkg::KEY_W-1:0]     i_hv,
    output logic                                 o_above,
    output logic signed [lcv_pkg::KEY_W-1:0]     o_hv,
    output logic signed [lcv_pkg::KEY_W-1:0]     o_key,
    output logic signed [lcv_pkg::KEY_W-1:0]     o_value
);
    import lcv_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_value;
    logic                    r_match;
    logic                    w_valid;
    logic                    w_match;
    logic                    w_shift;

    // Slot is occupied when its index is below the fill count
    assign w_valid = (CW'(IDX) < i_count);
    assign w_match = w_valid && (r_key == i_req_key);

    // Pass the matched value and the match-seen flag down the chain
    assign o_hv    = i_hv | (w_match ? r_value : '0);
    assign o_above = i_above | r_match;

    // Shift on a hit at or above the matching slot, or on any insertion
    assign w_shift = i_ctl.upd && (i_ctl.hit ? !i_above : i_ctl.put);

    assign o_key   = r_key;
    assign o_value = r_value;

    // Capture the compare result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= w_match;
        end
    end

    // Take the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

endmodule

@@ rtl/core/lru_cache_key_value.sv @@
// Flow: a transferred request passes the compare and update states, then its result
// is registered into the output register; a stalled result holds the update. The
// sequencer that runs the cell chain takes no new request until the last one is done.
// Reset: synchronous active-low; the fill count clears so every slot is empty,
// capacity returns to 16, no result is pending. Entry payloads are not cleared.
`include "assert_macros.svh"

module lru_cache_key_value #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcv_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_write_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic signed [lcv_pkg::KEY_W-1:0]  o_read_value,
    output logic                              o_evicted,
    output logic signed [lcv_pkg::KEY_W-1:0]  o_evicted_key
);
    import lcv_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    t_state                  r_state, n_state;
    logic [CAP_W-1:0]        r_cap;
    logic [CW-1:0]           r_count;
    logic                    r_req_put;
    logic signed [KEY_W-1:0] r_req_key;
    logic signed [KEY_W-1:0] r_req_value;
    logic signed [KEY_W-1:0] r_hit_value;
    logic signed [KEY_W-1:0] r_ev_key;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic signed [KEY_W-1:0] r_out_read;
    logic                    r_out_evicted;
    logic signed [KEY_W-1:0] r_out_ev_key;

    logic                    w_accept;
    logic                    w_fire;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_evict;
    logic [XW-1:0]           w_effcap;
    logic [IW-1:0]           w_last;
    logic signed [KEY_W-1:0] w_head_value;
    t_cell_ctl               w_ctl;

    logic signed [KEY_W-1:0] w_key   [ENTRIES];
    logic signed [KEY_W-1:0] w_value [ENTRIES];
    logic                    w_above [ENTRIES+1];
    logic signed [KEY_W-1:0] w_hv    [ENTRIES+1];

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        w_fire     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_fire  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(CAP_RST);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Hold the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_put   <= i_req_type;
            r_req_key   <= i_lookup_key;
            r_req_value <= i_write_value;
        end
    end

    // Clamp capacity into one..ENTRIES
    always_comb begin
        w_effcap = XW'(r_cap);
        if (r_cap == '0) begin
            w_effcap = XW'(1);
        end else if (XW'(r_cap) > XW'(ENTRIES)) begin
            w_effcap = XW'(ENTRIES);
        end
    end

    assign w_hit   = w_above[ENTRIES];
    assign w_full  = (XW'(r_count) >= w_effcap);
    assign w_evict = r_req_put && !w_hit && w_full && (r_count != '0);
    assign w_last  = IW'(r_count - 1'b1);

    // Cell control
    assign w_ctl.cmp = (r_state == S_MATCH);
    assign w_ctl.upd = w_fire;
    assign w_ctl.hit = w_hit;
    assign w_ctl.put = r_req_put;

    // Head of the chain: promoted or inserted entry
    assign w_head_value = r_req_put ? r_req_value : r_hit_value;
    assign w_above[0]   = 1'b0;
    assign w_hv[0]      = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic signed [KEY_W-1:0] w_pk;
            logic signed [KEY_W-1:0] w_pv;
            if (gi == 0) begin : g_head
                assign w_pk = r_req_key;
                assign w_pv = w_head_value;
            end else begin : g_link
                assign w_pk = w_key[gi-1];
                assign w_pv = w_value[gi-1];
            end
            lcv_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_req_key    (r_req_key),
                .i_prev_key   (w_pk),
                .i_prev_value (w_pv),
                .i_above      (w_above[gi]),
                .i_hv         (w_hv[gi]),
                .o_above      (w_above[gi+1]),
                .o_hv         (w_hv[gi+1]),
                .o_key        (w_key[gi]),
                .o_value      (w_value[gi])
            );
        end
    endgenerate

    // Latch matched value and least recent key during compare
    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH) begin
            r_hit_value <= w_hv[ENTRIES];
            r_ev_key    <= w_key[w_last];
        end
    end

    // Advance the fill count on an insertion without eviction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire && r_req_put && !w_hit && !w_evict) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_hit     <= w_hit;
            r_out_evicted <= w_evict;
            r_out_ev_key  <= w_evict ? r_ev_key : '0;
            if (r_req_put) begin
                r_out_read <= '0;
            end else if (w_hit) begin
                r_out_read <= r_hit_value;
            end else begin
                r_out_read <= '1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_read;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_ev_key;

    `ASSERT_CLK(a_count_bound, (r_count <= CW'(ENTRIES)), "fill count above entry count")
    `ASSERT_CLK(a_accept_seq, (w_accept |=> (r_state == S_MATCH)), "transfer not followed by compare")
    `ASSERT_CLK(a_evict_miss, ((o_out_valid && o_evicted) |-> !o_hit), "eviction reported on a hit")
    `ASSERT_CLK(a_count_step,
        ((r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)),
        "fill count moved by more than one")

endmodule

@@ bench/lru_checker.sv @@
`timescale 1ns / 1ps

module lru_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcv_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_req_type,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_write_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic                              i_hit,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_read_value,
    input  logic                              i_evicted,
    input  logic signed [lcv_pkg::KEY_W-1:0]  i_evicted_key,
    output int                                o_pending,
    output int                                o_mismatches
);

    typedef struct packed {
        logic                             hit;
        logic signed [lcv_pkg::KEY_W-1:0] read_value;
        logic                             evicted;
        logic signed [lcv_pkg::KEY_W-1:0] evicted_key;
    } t_lookup_result;

    localparam logic signed [lcv_pkg::KEY_W-1:0] MISS_VALUE = -1;
    localparam int REPORT_LIMIT = 10;

    // Recency-ordered copy of the store: slot 0 is the most recent entry.
    logic signed [lcv_pkg::KEY_W-1:0] slot_key   [ENTRIES];
    logic signed [lcv_pkg::KEY_W-1:0] slot_value [ENTRIES];
    int                               fill_count;
    logic [lcv_pkg::CAP_W-1:0]        capacity_reg;
    t_lookup_result                   lookups_due [$];

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        fill_count   = 0;
        capacity_reg = lcv_pkg::CAP_W'(lcv_pkg::CAP_RST);
    end

    // Clamp the capacity register to the range the store can honor.
    function automatic int effective_capacity();
        int c;
        c = int'(capacity_reg);
        if (c < 1) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // Move slot pos to the front, pushing the more recent entries down by one.
    function automatic void promote_slot(int pos);
        logic signed [lcv_pkg::KEY_W-1:0] k;
        logic signed [lcv_pkg::KEY_W-1:0] v;
        int i;
        k = slot_key[pos];
        v = slot_value[pos];
        for (i = pos; i > 0; i--) begin
            slot_key[i]   = slot_key[i-1];
            slot_value[i] = slot_value[i-1];
        end
        slot_key[0]   = k;
        slot_value[0] = v;
    endfunction

    // Apply one request to the store copy and return the result it yields.
    function automatic t_lookup_result lookup_and_update(
        logic                             is_put,
        logic signed [lcv_pkg::KEY_W-1:0] key,
        logic signed [lcv_pkg::KEY_W-1:0] val
    );
        t_lookup_result res;
        int pos;
        int i;
        res = '0;
        pos = -1;
        for (i = 0; i < fill_count; i++) begin
            if (pos < 0 && slot_key[i] == key) pos = i;
        end
        if (pos >= 0) begin
            res.hit = 1'b1;
            if (is_put) slot_value[pos] = val;
            else res.read_value = slot_value[pos];
            promote_slot(pos);
        end else if (!is_put) begin
            res.read_value = MISS_VALUE;
        end else begin
            // Evict the least recent entry when full, even if capacity was lowered.
            if (fill_count >= effective_capacity()) begin
                res.evicted     = 1'b1;
                res.evicted_key = slot_key[fill_count-1];
                fill_count--;
            end
            for (i = fill_count; i > 0; i--) begin
                slot_key[i]   = slot_key[i-1];
                slot_value[i] = slot_value[i-1];
            end
            slot_key[0]   = key;
            slot_value[0] = val;
            fill_count++;
        end
        return res;
    endfunction

    // Compare one result transfer against the oldest outstanding lookup.
    task automatic compare_result(input t_lookup_result got);
        t_lookup_result want;
        logic           bad;
        if (lookups_due.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("%0t: result with no request outstanding: hit=%0b rd=%0d ev=%0b evk=%0d",
                         $time, got.hit, got.read_value, got.evicted, got.evicted_key);
            return;
        end
        want = lookups_due.pop_front();
        bad  = (got.hit !== want.hit) || (got.read_value !== want.read_value) ||
               (got.evicted !== want.evicted) || (got.evicted_key !== want.evicted_key);
        if (bad) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT) begin
                $display("%0t: mismatch expected hit=%0b rd=%0d ev=%0b evk=%0d",
                         $time, want.hit, want.read_value, want.evicted, want.evicted_key);
                $display("%0t:          actual   hit=%0b rd=%0d ev=%0b evk=%0d",
                         $time, got.hit, got.read_value, got.evicted, got.evicted_key);
            end
        end
    endtask

    // Track config writes, predict each request transfer, check each result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_count   = 0;
            capacity_reg = lcv_pkg::CAP_W'(lcv_pkg::CAP_RST);
            lookups_due.delete();
        end else begin
            if (i_cfg_we) capacity_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                lookups_due.push_back(lookup_and_update(i_req_type, i_lookup_key,
                                                        i_write_value));
            if (i_out_valid && !i_out_stall)
                compare_result('{i_hit, i_read_value, i_evicted, i_evicted_key});
        end
        o_pending = lookups_due.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;
    localparam logic signed [lcv_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [lcv_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam int ENTRIES         = 16;
    localparam int KEY_POOL        = 24;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 136;
    localparam int SETTLE_CYCLES   = 6;
    localparam int QUIET_LIMIT     = 1000;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [lcv_pkg::CAP_W-1:0]        i_cfg_data    = '0;
    logic                             i_in_valid    = 1'b0;
    logic                             o_in_stall;
    logic                             i_req_type    = REQ_GET;
    logic signed [lcv_pkg::KEY_W-1:0] i_lookup_key  = '0;
    logic signed [lcv_pkg::KEY_W-1:0] i_write_value = '0;
    logic                             o_out_valid;
    logic                             i_out_stall   = 1'b0;
    logic                             o_hit;
    logic signed [lcv_pkg::KEY_W-1:0] o_read_value;
    logic                             o_evicted;
    logic signed [lcv_pkg::KEY_W-1:0] o_evicted_key;

    int   results_pending;
    int   mismatch_count;
    bit   no_idle      = 1'b0;
    logic out_taken    = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   key_span     = 4;
    logic signed [lcv_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    always #4 i_clk = ~i_clk;

    lru_cache_key_value #(.ENTRIES(ENTRIES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    lru_checker #(.ENTRIES(ENTRIES)) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_hit         (o_hit),
        .i_read_value  (o_read_value),
        .i_evicted     (o_evicted),
        .i_evicted_key (o_evicted_key),
        .o_pending     (results_pending),
        .o_mismatches  (mismatch_count)
    );

    // Idle cycles before the next transfer; zero during back-to-back stretches.
    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Capacity for each random phase; low values follow high ones to shrink a full store.
    function automatic logic [lcv_pkg::CAP_W-1:0] phase_capacity(int phase);
        case (phase)
            0:       return 16;
            1:       return 1;
            2:       return 31;
            3:       return 4;
            4:       return 0;
            5:       return 9;
            6:       return 2;
            7:       return 12;
            8:       return 3;
            9:       return 31;
            10:      return 8;
            default: return 5;
        endcase
    endfunction

    // Mostly reuse keys from a small pool so hits, updates and evictions stay frequent.
    function automatic logic signed [lcv_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, key_span - 1)];
        return $urandom;
    endfunction

    function automatic logic signed [lcv_pkg::KEY_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Hold off, then present one request until it transfers.
    task automatic send_req(
        input logic                             kind,
        input logic signed [lcv_pkg::KEY_W-1:0] key,
        input logic signed [lcv_pkg::KEY_W-1:0] val
    );
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_lookup_key  <= key;
        i_write_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every outstanding result has transferred.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [lcv_pkg::CAP_W-1:0] cap);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Note each result transfer so the receiver can draw its next stall.
    always @(posedge i_clk) out_taken <= o_out_valid && !i_out_stall;

    // Hold stall high for a drawn number of cycles after each result transfer.
    always @(negedge i_clk) begin
        if (out_taken) stall_left = idle_cycles();
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Abort when no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        int cap;
        logic kind;

        for (n = 0; n < KEY_POOL; n++) key_pool[n] = $urandom;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty store, extreme keys and values, update, hit and miss.
        send_req(REQ_GET, '0, 32'sh0BAD_F00D);
        send_req(REQ_PUT, KEY_MIN, KEY_MAX);
        send_req(REQ_PUT, KEY_MAX, KEY_MIN);
        send_req(REQ_PUT, '0, '0);
        send_req(REQ_PUT, -1, -1);
        send_req(REQ_GET, KEY_MIN, '0);
        send_req(REQ_PUT, KEY_MAX, 32'sh5555_5555);
        send_req(REQ_GET, KEY_MAX, -1);
        send_req(REQ_GET, 32'sh1234_5678, '0);
        send_req(REQ_GET, -1, '0);

        // Directed: capacity zero acts as one, applied to an already populated store.
        set_capacity('0);
        send_req(REQ_PUT, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
        send_req(REQ_PUT, 32'sh5555_5555, 32'shF0F0_F0F0);
        send_req(REQ_GET, 32'shAAAA_AAAA, '0);
        send_req(REQ_GET, '0, '0);
        send_req(REQ_PUT, 32'sh0000_0001, 32'sh0000_0002);
        send_req(REQ_GET, 32'sh5555_5555, '0);

        // Random phases, each with its own capacity and key reuse span.
        for (phase = 0; phase < PHASES; phase++) begin
            cap = int'(phase_capacity(phase));
            set_capacity(lcv_pkg::CAP_W'(cap));
            if (cap > ENTRIES) cap = ENTRIES;
            key_span = cap + $urandom_range(2, 6);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
                kind = ($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET;
                send_req(kind, pick_key(), pick_value());
            end
        end

        drain_results();
        if (mismatch_count == 0 && results_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lcv_pkg.sv
rtl/core/lcv_cell.sv
rtl/core/lru_cache_key_value.sv
bench/lru_checker.sv
bench/tb_top.sv
